FILE: design/mpab_pkg.sv
`timescale 1ns / 1ps
package mpab_pkg;

    localparam int NUM_POOLS   = 16;
    localparam int IDX_W       = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int CNT_W       = $clog2(NUM_POOLS + 1);
    localparam int SIZE_W      = 40;
    localparam int ALIGN_W     = 33;
    localparam int TYPE_W      = 5;
    localparam int OUT_IDX_W   = 4;
    localparam int DIV_STEPS   = SIZE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [SIZE_W-1:0] BLOCK_RESET = 40'd67108864;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // one input beat
    typedef struct packed {
        logic                command;
        logic [TYPE_W-1:0]   mem_type;
        logic [SIZE_W-1:0]   req_size;
        logic [ALIGN_W-1:0]  req_align;
    } t_item;

    // one result beat
    typedef struct packed {
        logic                 ok;
        logic [OUT_IDX_W-1:0] pool_index;
        logic [SIZE_W-1:0]    alloc_offset;
        logic [SIZE_W-1:0]    alloc_size;
        logic                 new_pool;
    } t_result;

    // request as broadcast to the pool cells
    typedef struct packed {
        logic [TYPE_W-1:0]  mem_type;
        logic [SIZE_W-1:0]  size;
        logic [ALIGN_W-1:0] align;
        logic [SIZE_W-1:0]  cap_new;
        logic               shareable;
    } t_req;

    // phase strobes from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic align;
        logic fit;
    } t_ctl;

    // a cell taking the request
    typedef struct packed {
        logic              hit;
        logic              append;
        logic [SIZE_W-1:0] offset;
    } t_claim;

endpackage

FILE: design/mpab_cell.sv
`timescale 1ns / 1ps
module mpab_cell import mpab_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctl   i_ctl,
    input  t_req   i_req,
    input  logic   i_valid,
    input  logic   i_tok,
    output logic   o_tok,
    output t_claim o_claim
);

    // pool entry
    logic [TYPE_W-1:0]  r_type;
    logic [SIZE_W-1:0]  r_cap;
    logic [SIZE_W-1:0]  r_off;

    // bit-serial remainder of offset / align
    logic [SIZE_W-1:0]  r_dvd;
    logic [ALIGN_W-1:0] r_rem;
    logic [SIZE_W:0]    r_alg;
    logic               r_fit;

    logic               r_tok;
    logic               r_hit;
    logic               r_app;
    logic [SIZE_W-1:0]  r_coff;

    logic [ALIGN_W:0]   w_trial;
    logic [ALIGN_W:0]   w_diff;
    logic               w_ge;
    logic [ALIGN_W-1:0] n_rem;
    logic [ALIGN_W-1:0] w_pad;
    logic [SIZE_W:0]    w_alg;
    logic [SIZE_W+1:0]  w_end;
    logic               w_fits;
    logic               w_match;
    logic               w_take_hit;
    logic               w_take_app;

    always_comb begin
        w_trial = {r_rem, r_dvd[SIZE_W-1]};
        w_diff  = w_trial - {1'b0, i_req.align};
        w_ge    = w_trial >= {1'b0, i_req.align};
        n_rem   = w_ge ? w_diff[ALIGN_W-1:0] : w_trial[ALIGN_W-1:0];
        // round up: add the distance to the next multiple
        w_pad   = (r_rem != '0) ? (i_req.align - r_rem) : '0;
        w_alg   = {1'b0, r_off} + (SIZE_W+1)'(w_pad);
        w_end   = {1'b0, r_alg} + (SIZE_W+2)'(i_req.size);
        // a zero-size request fits even when the aligned offset is past the end
        w_fits  = (i_req.size == '0) || (w_end <= {2'b00, r_cap});
        w_match = i_valid && (r_type == i_req.mem_type) && i_req.shareable && r_fit;
        w_take_hit = i_tok && w_match;
        w_take_app = i_tok && !i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_hit <= 1'b0;
            r_app <= 1'b0;
        end else begin
            r_tok <= i_tok && i_valid && !w_match;
            r_hit <= w_take_hit;
            r_app <= w_take_app;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= r_off;
            r_rem <= '0;
        end else if (i_ctl.shift) begin
            r_dvd <= {r_dvd[SIZE_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
        if (i_ctl.align) begin
            r_alg <= w_alg;
        end
        if (i_ctl.fit) begin
            r_fit <= w_fits;
        end
        if (w_take_hit) begin
            r_off  <= w_end[SIZE_W-1:0];
            r_coff <= r_alg[SIZE_W-1:0];
        end else if (w_take_app) begin
            r_type <= i_req.mem_type;
            r_cap  <= i_req.cap_new;
            r_off  <= i_req.size;
            r_coff <= '0;
        end
    end

    assign o_tok          = r_tok;
    assign o_claim.hit    = r_hit;
    assign o_claim.append = r_app;
    assign o_claim.offset = r_coff;

endmodule

FILE: design/multi_pool_aligned_bump_allocator.sv
// pooled bump allocator with per-request alignment
//
// command channel: an item is taken at a clock edge with i_start high and
// o_busy low. an allocate beat names a memory type, a size and an alignment
// (0 means 1); a release beat empties the pool table.
// result channel: o_done is high for exactly one cycle with the result on
// o_result; the receiver cannot stall, so the result is simply dropped onto
// the ports and the next beat may be issued in that same cycle.
// config: i_cfg_we writes i_cfg_wdata into the block size register at once.
//
// sequence: release answers in the cycle after the accepting edge with no busy
// time. allocate runs load, a 40-step bit-serial remainder done in every
// pool cell at once, align and fit, then a token walks the chain of pool
// cells one per cycle until a pool takes the request or the chain ends;
// o_done rises and o_busy drops in that same cycle.
// reset: pool table empty, block size 64 MiB, no result pending.
`timescale 1ns / 1ps
module multi_pool_aligned_bump_allocator import mpab_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_item             i_item,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ALIGN = 3'd3;
    localparam logic [2:0] S_FIT   = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_count;     // pools in use
    logic [SIZE_W-1:0]    r_block;
    t_req                 r_req;
    logic                 r_tok0;
    logic                 r_done;
    t_result              r_res;

    logic                 w_accept;
    logic                 w_small;
    t_ctl                 w_ctl;
    logic [NUM_POOLS:0]   w_tok;       // token chain between cells
    t_claim               w_claim [NUM_POOLS];
    logic [NUM_POOLS-1:0] w_taken;
    logic                 w_any;
    logic                 w_app;
    logic [IDX_W-1:0]     w_idx;
    logic [SIZE_W-1:0]    w_off;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;
    assign w_small  = i_item.req_size <= r_block;

    // phase strobes shared by every cell
    always_comb begin
        w_ctl.load  = (r_state == S_LOAD);
        w_ctl.shift = (r_state == S_DIV);
        w_ctl.align = (r_state == S_ALIGN);
        w_ctl.fit   = (r_state == S_FIT);
    end

    assign w_tok[0] = r_tok0;

    // the row of pool cells; the token enters at pool 0 and stops at the
    // first fitting pool or the first empty slot
    for (genvar k = 0; k < NUM_POOLS; k++) begin : g_pool
        mpab_cell u_pool (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_req   (r_req),
            .i_valid (CNT_W'(k) < r_count),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1]),
            .o_claim (w_claim[k])
        );
        assign w_taken[k] = w_claim[k].hit || w_claim[k].append;
    end

    // at most one cell claims, so an or of the selected fields is enough
    always_comb begin
        w_any = 1'b0;
        w_app = 1'b0;
        w_idx = '0;
        w_off = '0;
        for (int k = 0; k < NUM_POOLS; k++) begin
            if (w_taken[k]) begin
                w_any = 1'b1;
                w_app = w_claim[k].append;
                w_idx = IDX_W'(k);
                w_off = w_claim[k].offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_count <= '0;
            r_block <= BLOCK_RESET;
            r_tok0  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_tok0 <= 1'b0;
            if (i_cfg_we) begin
                r_block <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.command == CMD_RELEASE) begin
                            r_count <= '0;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    r_state <= S_FIT;
                end
                S_FIT: begin
                    r_tok0  <= 1'b1;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (w_any || w_tok[NUM_POOLS]) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (w_any && w_app) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: request latch and result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.mem_type     <= i_item.mem_type;
            r_req.size         <= i_item.req_size;
            r_req.align        <= (i_item.req_align == '0) ? ALIGN_W'(1) : i_item.req_align;
            r_req.cap_new      <= w_small ? r_block : i_item.req_size;
            r_req.shareable    <= w_small;
            r_res.ok           <= (i_item.command == CMD_RELEASE);
            r_res.pool_index   <= '0;
            r_res.alloc_offset <= '0;
            r_res.alloc_size   <= '0;
            r_res.new_pool     <= 1'b0;
        end else if (r_state == S_WALK) begin
            r_res.ok           <= w_any;
            r_res.pool_index   <= w_any ? OUT_IDX_W'(w_idx) : '0;
            r_res.alloc_offset <= w_any ? w_off : '0;
            r_res.alloc_size   <= w_any ? r_req.size : '0;
            r_res.new_pool     <= w_any && w_app;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_one_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_taken))
        else $error("more than one pool cell claimed the request");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one search token in the pool chain");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_POOLS))
        else $error("pool count above table size");

    a_new_pool_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.new_pool |-> r_count == $past(r_count) + 1'b1)
        else $error("new pool reported without count growth");

    a_claim_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_taken != '0) |-> r_state == S_WALK)
        else $error("pool claim outside the search walk");
`endif

endmodule

FILE: bench/pool_alloc_checker.sv
`timescale 1ns / 1ps
module pool_alloc_checker import mpab_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_item             i_item,
    input  logic              i_done,
    input  t_result           i_result,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output int                o_grants_owed,
    output int                o_errors
);

    // shadow of the pool table
    logic [SIZE_W-1:0] block_size;
    int                n_pools;
    logic [TYPE_W-1:0] pool_kind [NUM_POOLS];
    logic [SIZE_W-1:0] pool_cap  [NUM_POOLS];
    logic [SIZE_W-1:0] pool_bump [NUM_POOLS];

    t_result expected_grants [$];
    int      n_err = 0;

    assign o_errors = n_err;

    function automatic logic [63:0] round_to_align(logic [63:0] off, logic [63:0] al);
        return ((off + al - 64'd1) / al) * al;
    endfunction

    // grant for one beat, updates the shadow table
    function automatic t_result serve_request(t_item it);
        t_result     r;
        logic [63:0] al;
        logic [63:0] a;
        logic [63:0] room;
        int          found;
        bit          hit;
        r     = '0;
        found = 0;
        hit   = 1'b0;
        if (it.command == CMD_RELEASE) begin
            n_pools = 0;
            r.ok    = 1'b1;
            return r;
        end
        al = 64'(it.req_align);
        if (al == 64'd0) begin
            al = 64'd1;
        end
        // first fit among pools of the same type, only for non-dedicated sizes
        if (it.req_size <= block_size) begin
            for (int p = 0; p < n_pools; p++) begin
                if (!hit && pool_kind[p] == it.mem_type) begin
                    a    = round_to_align(64'(pool_bump[p]), al);
                    room = (a < 64'(pool_cap[p])) ? 64'(pool_cap[p]) - a : 64'd0;
                    if (64'(it.req_size) <= room) begin
                        hit   = 1'b1;
                        found = p;
                    end
                end
            end
        end
        if (!hit) begin
            if (n_pools >= NUM_POOLS) begin
                return r;
            end
            found            = n_pools;
            pool_kind[found] = it.mem_type;
            pool_cap[found]  = (it.req_size > block_size) ? it.req_size : block_size;
            pool_bump[found] = '0;
            n_pools++;
            r.new_pool = 1'b1;
        end
        a                = round_to_align(64'(pool_bump[found]), al);
        pool_bump[found] = SIZE_W'(a + 64'(it.req_size));
        r.ok             = 1'b1;
        r.pool_index     = OUT_IDX_W'(found);
        r.alloc_offset   = SIZE_W'(a);
        r.alloc_size     = it.req_size;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            block_size = BLOCK_RESET;
            n_pools    = 0;
            expected_grants.delete();
        end else begin
            if (i_done) begin
                if (expected_grants.size() == 0) begin
                    $error("result beat with no request outstanding");
                    n_err++;
                end else begin
                    want = expected_grants.pop_front();
                    check_field("ok", 64'(want.ok), 64'(i_result.ok));
                    check_field("pool_index", 64'(want.pool_index),
                                64'(i_result.pool_index));
                    check_field("alloc_offset", 64'(want.alloc_offset),
                                64'(i_result.alloc_offset));
                    check_field("alloc_size", 64'(want.alloc_size),
                                64'(i_result.alloc_size));
                    check_field("new_pool", 64'(want.new_pool), 64'(i_result.new_pool));
                end
            end
            if (i_cfg_we) begin
                block_size = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                expected_grants = {expected_grants, serve_request(i_item)};
            end
        end
        o_grants_owed <= expected_grants.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb import mpab_pkg::*;;

    // random part length and the quiet-cycle limit of the watchdog
    localparam int N_ITEMS   = 650;
    localparam int QUIET_MAX = 2000;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    t_item             item      = '0;
    logic              done;
    t_result           result;
    logic              cfg_we    = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    int grants_owed;
    int n_errors;
    int n_sent  = 0;
    int quiet   = 0;
    bit idle_on = 1'b1;

    // block size currently in force, steers the size mix
    logic [SIZE_W-1:0] cur_bs = BLOCK_RESET;

    multi_pool_aligned_bump_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (item),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    pool_alloc_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (item),
        .i_done        (done),
        .i_result      (result),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_grants_owed (grants_owed),
        .o_errors      (n_errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles with neither a command beat nor a result beat
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done) begin
                quiet <= 0;
            end else begin
                quiet <= quiet + 1;
            end
            if (quiet >= QUIET_MAX) begin
                $display("[multi_pool_aligned_bump_allocator] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [SIZE_W-1:0] rand40();
        return SIZE_W'({$urandom, $urandom});
    endfunction

    // uniform-ish value in 0..hi
    function automatic logic [SIZE_W-1:0] rand_upto(logic [SIZE_W-1:0] hi);
        logic [63:0] r;
        if (hi <= 40'h00_FFFF_FFFF) begin
            return SIZE_W'($urandom_range(hi[31:0], 0));
        end
        r = {$urandom, $urandom};
        return SIZE_W'(r % (64'(hi) + 64'd1));
    endfunction

    // mostly sizes that share a pool, some exact fits and some dedicated ones
    function automatic logic [SIZE_W-1:0] pick_size(logic [SIZE_W-1:0] bs);
        case ($urandom_range(9, 0)) inside
            0: begin
                return '0;
            end
            [1:5]: begin
                return rand_upto(bs >> 3);
            end
            [6:7]: begin
                return rand_upto(bs);
            end
            8: begin
                return bs;
            end
            default: begin
                if (bs == '1) begin
                    return rand40();
                end
                return bs + 40'd1 + rand_upto((~bs) >> 1);
            end
        endcase
    endfunction

    // zero, powers of two, small values from 3 to 100, random values and the largest power of two
    function automatic logic [ALIGN_W-1:0] pick_align();
        case ($urandom_range(9, 0)) inside
            0: begin
                return '0;
            end
            1: begin
                return ALIGN_W'(1);
            end
            [2:5]: begin
                return ALIGN_W'(1) << $urandom_range(12, 0);
            end
            6: begin
                return ALIGN_W'(1) << $urandom_range(32, 0);
            end
            7: begin
                return ALIGN_W'($urandom_range(100, 3));
            end
            8: begin
                return ALIGN_W'(33'h1_0000_0000);
            end
            default: begin
                return ALIGN_W'($urandom);
            end
        endcase
    endfunction

    function automatic t_item alloc_beat(logic [TYPE_W-1:0] ty, logic [SIZE_W-1:0] sz,
                                         logic [ALIGN_W-1:0] al);
        t_item it;
        it.command   = CMD_ALLOC;
        it.mem_type  = ty;
        it.req_size  = sz;
        it.req_align = al;
        return it;
    endfunction

    // release ignores the other fields, so they carry junk
    function automatic t_item release_beat();
        t_item it;
        it.command   = CMD_RELEASE;
        it.mem_type  = TYPE_W'($urandom);
        it.req_size  = rand40();
        it.req_align = pick_align();
        return it;
    endfunction

    // present one beat and return at the edge that takes it
    task automatic send(t_item it);
        int gap;
        if (idle_on && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(16, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        n_sent++;
    endtask

    // hold off until every outstanding grant has come back
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (grants_owed != 0);
    endtask

    task automatic write_block_size(logic [SIZE_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_bs = v;
    endtask

    initial begin
        logic [TYPE_W-1:0] types [3];
        logic [SIZE_W-1:0] v;
        int                ph;
        int                phase_end;
        int                nt;
        int                len;
        int                k;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero alignment, plain bumps and an alignment that pushes past the pool
        send(alloc_beat(5'd0, 40'd0, 33'd0));
        send(alloc_beat(5'd0, 40'd100, 33'd0));
        send(alloc_beat(5'd0, 40'd64, 33'd64));
        send(alloc_beat(5'd0, 40'd1, 33'h1_0000_0000));
        // largest size gets a dedicated pool, then that pool is exactly full
        send(alloc_beat(5'd31, '1, 33'h1_0000_0000));
        send(alloc_beat(5'd31, 40'd1, 33'd3));
        // zero size on a full pool, the aligned offset runs past 40 bits
        send(alloc_beat(5'd31, 40'd0, 33'd7));
        // one over the block size is dedicated, exactly the block size is not
        send(alloc_beat(5'd5, BLOCK_RESET + 40'd1, 33'd1));
        send(alloc_beat(5'd5, BLOCK_RESET, 33'd0));
        send(alloc_beat(5'd5, 40'd0, 33'd1));
        // fill the table, then a request that needs a new pool must fail
        for (int i = 0; i < 10; i++) begin
            send(alloc_beat(TYPE_W'(i * 3 + 1), BLOCK_RESET, 33'd0));
        end
        send(alloc_beat(5'd2, 40'd1, 33'd0));
        // a full table still serves from an existing pool
        send(alloc_beat(5'd0, 40'd0, 33'd0));
        send(release_beat());

        // random phases, each under its own block size; the first three are
        // the smallest, the largest and zero
        ph = 0;
        while (n_sent < N_ITEMS) begin
            case (ph)
                0: begin
                    v = 40'd1;
                end
                1: begin
                    v = '1;
                end
                2: begin
                    v = '0;
                end
                default: begin
                    case ($urandom_range(4, 0))
                        0: v = 40'd256;
                        1: v = 40'd4096;
                        2: v = BLOCK_RESET;
                        3: v = rand_upto(40'd1 << 20) + 40'd1;
                        default: v = rand40();
                    endcase
                end
            endcase
            write_block_size(v);
            if ($urandom_range(1, 0) == 1) begin
                send(release_beat());
            end
            phase_end = n_sent + 80;
            while (n_sent < phase_end && n_sent < N_ITEMS) begin
                // a run of requests over a few memory types
                nt = $urandom_range(3, 1);
                for (int t = 0; t < 3; t++) begin
                    types[t] = TYPE_W'($urandom_range(31, 0));
                end
                len = $urandom_range(30, 4);
                repeat (len) begin
                    idle_on = (n_sent < N_ITEMS - 100);
                    k = $urandom_range(19, 0);
                    if (k == 0) begin
                        send(release_beat());
                    end else if (k == 1) begin
                        send(alloc_beat(TYPE_W'($urandom_range(31, 0)), rand40(),
                                        pick_align()));
                    end else begin
                        send(alloc_beat(types[$urandom_range(nt - 1, 0)], pick_size(cur_bs),
                                        pick_align()));
                    end
                end
            end
            ph++;
        end

        settle();
        repeat (64) @(posedge clk);
        if (n_errors == 0 && grants_owed == 0) begin
            $display("[multi_pool_aligned_bump_allocator] OK");
        end else begin
            $display("[multi_pool_aligned_bump_allocator] ERROR");
        end
        $finish;
    end

endmodule
